// File: src/sync_length_frame_deframer_core_defines.svh
// Assertion helpers used by the checker file slfd_port_checker.sv.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Property checked while out of reset.
`define SLFD_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("slfd assertion failed");

// Property checked on every edge, reset included.
`define SLFD_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("slfd assertion failed");

`endif

// File: src/slfd_pkg.sv
package slfd_pkg;

    localparam logic [7:0] SYNC_BYTE0 = 8'h55;
    localparam logic [7:0] SYNC_BYTE1 = 8'h66;
    localparam logic [7:0] SYNC_BYTE3 = 8'hBB;

    localparam int HEADER_REST   = 4 + 1 + 4 + 2 + 1 + 4 - 4;
    localparam int TRAILER_BYTES = 4;
    localparam int TDATA_W       = 136;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    typedef struct packed {
        logic        known_command;
        logic [31:0] trailer_check;
        logic [31:0] header_check;
        logic [7:0]  command_id;
        logic [15:0] sequence_number;
        logic [31:0] payload_length;
        logic [7:0]  control_byte;
        logic        frame_end;
        logic [7:0]  payload_byte;
    } res_t;

    function automatic logic is_known_cmd(input logic [7:0] c);
        return c inside {8'h80, 8'h81, 8'h83, 8'h89, 8'h90, 8'h91, 8'h92, 8'h93,
                         8'h94, 8'h98, 8'h9E, 8'hA1, 8'hA2, 8'hA3, 8'hA6, 8'hAA,
                         8'hAB, 8'hAC, 8'hB0, 8'hBA, 8'hBB};
    endfunction

endpackage

// File: src/slfd_parser.sv
module slfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    output slfd_pkg::res_t      res
);

    localparam logic [3:0] HDR_LAST  = 4'(slfd_pkg::HEADER_REST - 1);
    localparam logic [1:0] TRL_LAST  = 2'(slfd_pkg::TRAILER_BYTES - 1);

    slfd_pkg::phase_t phase_reg, phase_next;
    logic [23:0] win_reg, win_next;
    logic [1:0]  fill_reg, fill_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] hchk_reg, hchk_next;
    logic [31:0] trl_reg, trl_next;

    logic        sync_hit;
    logic [31:0] cnt_inc;
    logic        pay_done;

    assign sync_hit = (fill_reg == 2'd3) && (win_reg[23:16] == slfd_pkg::SYNC_BYTE0)
                   && (win_reg[15:8] == slfd_pkg::SYNC_BYTE1)
                   && (in_byte == slfd_pkg::SYNC_BYTE3);
    assign cnt_inc  = cnt_reg + 32'd1;
    assign pay_done = (cnt_inc >= len_reg);

    always_comb begin
        phase_next = phase_reg;
        if (in_valid) begin
            case (phase_reg)
                slfd_pkg::PH_HUNT: begin
                    if (sync_hit) phase_next = slfd_pkg::PH_HEADER;
                end
                slfd_pkg::PH_HEADER: begin
                    if (cnt_reg[3:0] == HDR_LAST)
                        phase_next = (len_reg == 32'd0) ? slfd_pkg::PH_TRAILER
                                                        : slfd_pkg::PH_PAYLOAD;
                end
                slfd_pkg::PH_PAYLOAD: begin
                    if (pay_done) phase_next = slfd_pkg::PH_TRAILER;
                end
                slfd_pkg::PH_TRAILER: begin
                    if (cnt_reg[1:0] == TRL_LAST) phase_next = slfd_pkg::PH_HUNT;
                end
                default: phase_next = slfd_pkg::PH_HUNT;
            endcase
        end
    end

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        ctrl_next = ctrl_reg;
        len_next  = len_reg;
        seq_next  = seq_reg;
        cmd_next  = cmd_reg;
        hchk_next = hchk_reg;
        trl_next  = trl_reg;

        res_valid           = 1'b0;
        res.payload_byte    = in_byte;
        res.frame_end       = 1'b0;
        res.control_byte    = ctrl_reg;
        res.payload_length  = len_reg;
        res.sequence_number = seq_reg;
        res.command_id      = cmd_reg;
        res.header_check    = hchk_reg;
        res.trailer_check   = 32'd0;
        res.known_command   = slfd_pkg::is_known_cmd(cmd_reg);

        if (in_valid) begin
            case (phase_reg)
                slfd_pkg::PH_HUNT: begin
                    if (sync_hit) begin
                        win_next  = '0;
                        fill_next = '0;
                        cnt_next  = '0;
                        ctrl_next = '0;
                        len_next  = '0;
                        seq_next  = '0;
                        cmd_next  = '0;
                        hchk_next = '0;
                        trl_next  = '0;
                    end else begin
                        win_next = {win_reg[15:0], in_byte};
                        if (fill_reg != 2'd3) fill_next = fill_reg + 2'd1;
                    end
                end
                slfd_pkg::PH_HEADER: begin
                    case (cnt_reg[3:0])
                        4'd0:    ctrl_next        = in_byte;
                        4'd1:    len_next[7:0]    = in_byte;
                        4'd2:    len_next[15:8]   = in_byte;
                        4'd3:    len_next[23:16]  = in_byte;
                        4'd4:    len_next[31:24]  = in_byte;
                        4'd5:    seq_next[7:0]    = in_byte;
                        4'd6:    seq_next[15:8]   = in_byte;
                        4'd7:    cmd_next         = in_byte;
                        4'd8:    hchk_next[7:0]   = in_byte;
                        4'd9:    hchk_next[15:8]  = in_byte;
                        4'd10:   hchk_next[23:16] = in_byte;
                        default: hchk_next[31:24] = in_byte;
                    endcase
                    cnt_next = (cnt_reg[3:0] == HDR_LAST) ? 32'd0 : cnt_inc;
                end
                slfd_pkg::PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    cnt_next  = pay_done ? 32'd0 : cnt_inc;
                end
                default: begin
                    case (cnt_reg[1:0])
                        2'd0:    trl_next[7:0]   = in_byte;
                        2'd1:    trl_next[15:8]  = in_byte;
                        2'd2:    trl_next[23:16] = in_byte;
                        default: trl_next[31:24] = in_byte;
                    endcase
                    if (cnt_reg[1:0] == TRL_LAST) begin
                        res_valid           = 1'b1;
                        res.payload_byte    = 8'd0;
                        res.frame_end       = 1'b1;
                        res.trailer_check   = {in_byte, trl_reg[23:0]};
                        cnt_next            = 32'd0;
                        win_next            = '0;
                        fill_next           = '0;
                    end else begin
                        cnt_next = {30'd0, cnt_reg[1:0] + 2'd1};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= slfd_pkg::PH_HUNT;
            win_reg   <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            ctrl_reg  <= '0;
            len_reg   <= '0;
            seq_reg   <= '0;
            cmd_reg   <= '0;
            hchk_reg  <= '0;
            trl_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            ctrl_reg  <= ctrl_next;
            len_reg   <= len_next;
            seq_reg   <= seq_next;
            cmd_reg   <= cmd_next;
            hchk_reg  <= hchk_next;
            trl_reg   <= trl_next;
        end
    end

endmodule

// File: src/slfd_out_reg.sv
module slfd_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  slfd_pkg::res_t                     res,
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [slfd_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);

    logic           valid_reg, valid_next;
    slfd_pkg::res_t res_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load)          valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.frame_end;
    assign m_tuser  = res_reg.known_command;
    assign m_tdata  = {res_reg.trailer_check, res_reg.header_check, res_reg.command_id,
                       res_reg.sequence_number, res_reg.payload_length,
                       res_reg.control_byte, res_reg.payload_byte};

endmodule

// File: src/sync_length_frame_deframer_core.sv
// A result is registered and leaves on m_ in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_tready.
// Hunting, header and non-final trailer bytes produce no transfer on m_.
// Reset: aresetn low at a clock edge returns to sync hunting with an empty window
// and an empty result register.
module sync_length_frame_deframer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slfd_pkg::TDATA_W-1:0]  m_tdata,   // payload_byte, control_byte,
                                                     // payload_length, sequence_number,
                                                     // command_id, header_check,
                                                     // trailer_check
    output logic                          m_tlast,   // frame_end
    output logic                          m_tuser    // known_command
);

    logic           accept;
    logic           res_valid;
    slfd_pkg::res_t res;

    assign accept = s_tvalid && s_tready;

    slfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    slfd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && res_valid),
        .res      (res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: src/slfd_port_checker.sv
`include "sync_length_frame_deframer_core_defines.svh"

module slfd_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [slfd_pkg::TDATA_W-1:0]  m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);

    property p_hold_stalled;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser);
    endproperty

    property p_end_no_data;
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0;
    endproperty

    property p_pay_no_trl;
        m_tvalid && !m_tlast |-> m_tdata[slfd_pkg::TDATA_W-1 -: 32] == 32'd0;
    endproperty

    property p_end_spacing;
        m_tvalid && m_tready && m_tlast |=> !(m_tvalid && m_tlast);
    endproperty

    property p_reset_idle;
        !aresetn |=> !m_tvalid;
    endproperty

    `SLFD_ASSERT_CLK(a_hold_stalled, aclk, aresetn, p_hold_stalled)
    `SLFD_ASSERT_CLK(a_end_no_data, aclk, aresetn, p_end_no_data)
    `SLFD_ASSERT_CLK(a_pay_no_trl, aclk, aresetn, p_pay_no_trl)
    `SLFD_ASSERT_CLK(a_end_spacing, aclk, aresetn, p_end_spacing)
    `SLFD_ASSERT_ANY(a_reset_idle, aclk, p_reset_idle)

endmodule

bind sync_length_frame_deframer_core slfd_port_checker u_slfd_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
